// File: hdl/mse_pkg.sv
// Shared types and constants for the merge sort engine.
package mse_pkg;

  localparam int VAL_W = 32;

  typedef logic [VAL_W-1:0] mse_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;      // write the incoming value and bump the count
    logic sort_init;  // latch set size, start the first pass
    logic pass_next;  // double run width, swap buffers, restart at run zero
    logic run_init;   // set up the pointers of the next run pair
    logic rd;         // read both run heads
    logic mrg;        // write the smaller head to the destination buffer
    logic emit_init;  // rewind the output index
    logic emit_rd;    // read the next sorted entry
    logic emit_ld;    // load the output register
  } mse_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic width_done;  // run width covers the whole set
    logic lo_done;     // no run pair left in this pass
    logic run_done;    // current run pair fully merged
    logic emit_final;  // output index sits on the last entry
    logic out_full;    // output register holds an untaken result
  } mse_sts_t;

endpackage

// File: hdl/mse_in_if.sv
// Input channel: one value per transfer, last flag closes the set.
interface mse_in_if;
  import mse_pkg::*;

  logic      valid;
  logic      ready;
  mse_word_t value;
  logic      last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

// File: hdl/mse_out_if.sv
// Result channel: sorted values, final_res on the greatest one.
interface mse_out_if;
  import mse_pkg::*;

  logic      valid;
  logic      ready;
  mse_word_t sorted_value;
  logic      final_res;

  modport source (output valid, output sorted_value, output final_res, input ready);
  modport sink (input valid, input sorted_value, input final_res, output ready);
endinterface

// File: hdl/mse_dp.sv
// Datapath: two sort buffers, merge pointers, output register.
module mse_dp #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mse_pkg::mse_cmd_t cmd,
  output mse_pkg::mse_sts_t sts,
  input  mse_pkg::mse_word_t in_value,
  output logic              out_valid,
  output mse_pkg::mse_word_t out_value,
  output logic              out_final,
  input  logic              out_ready
);
  import mse_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 2;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  mse_word_t buf_a [DEPTH];
  mse_word_t buf_b [DEPTH];

  logic [CW-1:0] count_r, n_r, i_r, j_r, k_r, mid_r, hi_r;
  logic [SW-1:0] lo_r, width_r;
  logic          src_a_r;
  mse_word_t     a_q0_r, a_q1_r, b_q0_r, b_q1_r;
  logic          out_valid_r, out_final_r;
  mse_word_t     out_value_r;

  logic [CW-1:0] cnt_after, mid_nxt, hi_nxt;
  logic [SW-1:0] n_ext, sum_mid, sum_hi;
  logic [AW-1:0] addr0, addr1, wr_addr;
  mse_word_t     d0, d1, wr_data;
  logic          take_left, rd_en, we_a, we_b;

  always_comb begin
    cnt_after = (count_r < DEPTH_C) ? CW'(count_r + 1'b1) : count_r;
    n_ext     = SW'(n_r);
    sum_mid   = SW'(lo_r + width_r);
    sum_hi    = SW'(lo_r + (width_r << 1));
    mid_nxt   = (sum_mid > n_ext) ? n_r : sum_mid[CW-1:0];
    hi_nxt    = (sum_hi > n_ext) ? n_r : sum_hi[CW-1:0];

    addr0 = cmd.emit_rd ? k_r[AW-1:0] : i_r[AW-1:0];
    addr1 = j_r[AW-1:0];
    rd_en = cmd.rd || cmd.emit_rd;

    d0 = src_a_r ? a_q0_r : b_q0_r;
    d1 = src_a_r ? a_q1_r : b_q1_r;
    // Ties go to the left run to keep the sort stable.
    take_left = (i_r < mid_r) && ((j_r >= hi_r) || ($signed(d0) <= $signed(d1)));

    wr_data = cmd.store ? in_value : (take_left ? d0 : d1);
    wr_addr = cmd.store ? count_r[AW-1:0] : k_r[AW-1:0];
    we_a    = (cmd.store && (count_r < DEPTH_C)) || (cmd.mrg && !src_a_r);
    we_b    = cmd.mrg && src_a_r;
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      buf_a[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      a_q0_r <= buf_a[addr0];
      a_q1_r <= buf_a[addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      buf_b[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      b_q0_r <= buf_b[addr0];
      b_q1_r <= buf_b[addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sort_init) begin
        count_r <= '0;
      end else if (cmd.store) begin
        count_r <= cnt_after;
      end
      if (cmd.emit_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sort_init) begin
      n_r     <= cnt_after;
      width_r <= SW'(1);
      lo_r    <= '0;
      src_a_r <= 1'b1;
    end
    if (cmd.pass_next) begin
      width_r <= SW'(width_r << 1);
      lo_r    <= '0;
      src_a_r <= !src_a_r;
    end
    if (cmd.run_init) begin
      i_r   <= lo_r[CW-1:0];
      k_r   <= lo_r[CW-1:0];
      j_r   <= mid_nxt;
      mid_r <= mid_nxt;
      hi_r  <= hi_nxt;
      lo_r  <= sum_hi;
    end
    if (cmd.mrg) begin
      k_r <= CW'(k_r + 1'b1);
      if (take_left) begin
        i_r <= CW'(i_r + 1'b1);
      end else begin
        j_r <= CW'(j_r + 1'b1);
      end
    end
    if (cmd.emit_init) begin
      k_r <= '0;
    end
    if (cmd.emit_ld) begin
      k_r         <= CW'(k_r + 1'b1);
      out_value_r <= d0;
      out_final_r <= sts.emit_final;
    end
  end

  always_comb begin
    sts.width_done = width_r >= n_ext;
    sts.lo_done    = lo_r >= n_ext;
    sts.run_done   = k_r == hi_r;
    sts.emit_final = CW'(k_r + 1'b1) == n_r;
    sts.out_full   = out_valid_r;
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_final = out_final_r;

endmodule

// File: hdl/mse_ctrl.sv
// Controller: load, merge passes and emit sequencing.
module mse_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  mse_pkg::mse_sts_t sts,
  output mse_pkg::mse_cmd_t cmd
);
  import mse_pkg::*;

  localparam logic [2:0] S_LOAD    = 3'd0;
  localparam logic [2:0] S_PASS    = 3'd1;
  localparam logic [2:0] S_RUN     = 3'd2;
  localparam logic [2:0] S_RD      = 3'd3;
  localparam logic [2:0] S_MRG     = 3'd4;
  localparam logic [2:0] S_EMIT_RD = 3'd5;
  localparam logic [2:0] S_EMIT_LD = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready  = 1'b1;
        cmd.store = in_valid;
        if (in_valid && in_last) begin
          cmd.sort_init = 1'b1;
          state_nxt     = S_PASS;
        end
      end
      S_PASS: begin
        if (sts.width_done) begin
          cmd.emit_init = 1'b1;
          state_nxt     = S_EMIT_RD;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.lo_done) begin
          cmd.pass_next = 1'b1;
          state_nxt     = S_PASS;
        end else begin
          cmd.run_init = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        if (sts.run_done) begin
          state_nxt = S_RUN;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_MRG;
        end
      end
      S_MRG: begin
        cmd.mrg   = 1'b1;
        state_nxt = S_RD;
      end
      S_EMIT_RD: begin
        // Hold until the output register is free.
        if (!sts.out_full) begin
          cmd.emit_rd = 1'b1;
          state_nxt   = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_nxt   = sts.emit_final ? S_LOAD : S_EMIT_RD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hdl/merge_sort_engine_top.sv
// Top level of the merge sort engine: stable ascending sort of up to DEPTH values.
//
//   channel | dir | payload                 | transfer
//   in_ch   | in  | value[31:0], last       | valid && ready
//   out_ch  | out | sorted_value[31:0],     | valid && ready
//           |     | final_res               |
//
// Loading accepts one value per cycle. After the last value, the sort runs
// ceil(log2(n)) merge passes: per element, a registered two-port read of
// both run heads, then a compare and write, with setup steps per run pair
// and per pass, and an emit setup step after the last pass. Each result is
// read, then loaded into the output register, and the next read waits for the
// register to empty.
// Reset clears the controller, the element count and the output valid.
// A stalled output holds the emit sequence; input is taken again once the final
// result is in the output register.
module merge_sort_engine_top #(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  mse_in_if.sink     in_ch,
  mse_out_if.source  out_ch
);
  import mse_pkg::*;

  mse_cmd_t cmd;
  mse_sts_t sts;

  mse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mse_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_value  (in_ch.value),
    .out_valid (out_ch.valid),
    .out_value (out_ch.sorted_value),
    .out_final (out_ch.final_res),
    .out_ready (out_ch.ready)
  );

  // The closing transfer starts the sort, so input stops at once.
  a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.last |=> !in_ch.ready)
    else $error("input still ready after closing transfer");

  // No result can follow the final one without a new set.
  a_final_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.final_res |=> !out_ch.valid)
    else $error("result offered right after the final one");

  // A set stays open for input until its closing transfer.
  a_load_stays_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && !in_ch.last |=> in_ch.ready)
    else $error("input blocked in the middle of a set");

endmodule

// File: tb/sv/tb_merge_sort_engine_top.sv
// Testbench for merge_sort_engine_top: directed and random sets of signed values, sorted results checked.
module tb_merge_sort_engine_top;
  import mse_pkg::*;

  localparam int          SORT_DEPTH  = 64;
  localparam int unsigned ITEM_TARGET = 480;
  localparam int unsigned HOLD_AT     = 60;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 200;

  typedef struct packed {
    mse_word_t value;
    logic      fin;
  } sorted_entry_t;

  class sort_scoreboard;
    mse_word_t     open_set[$];
    sorted_entry_t sorted_q[$];
    int unsigned   max_set;
    int unsigned   mismatches;

    function new(int unsigned depth);
      max_set    = depth;
      mismatches = 0;
    endfunction

    // Store an accepted value; a closing transfer sorts the set (stable, ascending).
    function void note_input(mse_word_t v, logic last);
      mse_word_t     s[$];
      mse_word_t     key;
      int            j;
      sorted_entry_t e;
      if (open_set.size() < max_set) open_set.push_back(v);
      if (!last) return;
      s = open_set;
      for (int i = 1; i < s.size(); i++) begin
        key = s[i];
        j = i - 1;
        // strict compare keeps equal values in arrival order
        while (j >= 0 && $signed(s[j]) > $signed(key)) begin
          s[j+1] = s[j];
          j--;
        end
        s[j+1] = key;
      end
      foreach (s[i]) begin
        e.value = s[i];
        e.fin   = (i == s.size() - 1);
        sorted_q.push_back(e);
      end
      open_set.delete();
    endfunction

    function void check_result(mse_word_t got_v, logic got_f);
      sorted_entry_t e;
      if (sorted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d final=%b with nothing expected", $signed(got_v), got_f);
        return;
      end
      e = sorted_q.pop_front();
      if (got_v !== e.value || got_f !== e.fin) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected %0d final=%b, got %0d final=%b",
                   $signed(e.value), e.fin, $signed(got_v), got_f);
      end
    endfunction

    function int unsigned pending();
      return sorted_q.size();
    endfunction

    function int unsigned failures();
      return mismatches + sorted_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mse_in_if  in_ch();
  mse_out_if out_ch();

  sort_scoreboard sb = new(SORT_DEPTH);
  int unsigned    items_sent;

  merge_sort_engine_top #(
    .DEPTH(SORT_DEPTH)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mostly no gap, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  function automatic mse_word_t pick_value(mse_word_t prior[$]);
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: return $urandom;
      4, 5:       return mse_word_t'(int'($urandom_range(0, 16)) - 8);
      6: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      7: begin
        if ($urandom_range(0, 1) == 0) return 32'h8000_0000 + $urandom_range(0, 3);
        return 32'h7FFF_FFFF - $urandom_range(0, 3);
      end
      default: begin
        // repeat an earlier value of the set to create ties
        if (prior.size() == 0) return $urandom;
        return prior[$urandom_range(0, prior.size() - 1)];
      end
    endcase
  endfunction

  function automatic int unsigned pick_size(int unsigned set_no);
    int unsigned r;
    if (set_no == 3) return SORT_DEPTH;
    if (set_no == 6) return SORT_DEPTH + 3;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(1, 8);
    if (r < 85) return $urandom_range(9, 24);
    if (r < 95) return $urandom_range(25, SORT_DEPTH - 2);
    return $urandom_range(SORT_DEPTH - 1, SORT_DEPTH + 7);
  endfunction

  task automatic send_item(input mse_word_t v, input logic is_last);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(v, is_last);
    items_sent++;
  endtask

  task automatic idle_input(input int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_set(input mse_word_t vals[$], input bit calm);
    foreach (vals[i]) begin
      send_item(vals[i], i == vals.size() - 1);
      if (!calm) idle_input(pick_gap());
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin : stimulus
    mse_word_t   vals[$];
    int unsigned set_no;
    int unsigned n;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.last  = 1'b0;
    items_sent  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single-element sets at both extremes, then both extremes in one set
    vals = {32'h7FFF_FFFF};
    send_set(vals, 1'b0);
    vals = {32'h8000_0000};
    send_set(vals, 1'b1);
    vals = {32'h7FFF_FFFF, 32'h8000_0000};
    send_set(vals, 1'b0);
    // ties, zero and minus one among the extremes
    vals = {32'h0000_0005, 32'hFFFF_FFFD, 32'h0000_0005, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0005};
    send_set(vals, 1'b0);
    vals = {32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004};
    send_set(vals, 1'b1);
    vals = {32'h0000_0004, 32'h0000_0003, 32'h0000_0002, 32'h0000_0001,
            32'h0000_0000};
    send_set(vals, 1'b0);
    idle_input(1);
    wait_drained();

    set_no = 0;
    while (items_sent < ITEM_TARGET) begin
      vals.delete();
      n = pick_size(set_no);
      repeat (n) vals.push_back(pick_value(vals));
      send_set(vals, $urandom_range(0, 7) == 0);
      if (set_no == 12) begin
        idle_input(1);
        wait_drained();
      end
      set_no++;
    end
    idle_input(1);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (sb.failures() == 0) begin
      $display("tb_merge_sort_engine_top passed");
    end else begin
      $display("tb_merge_sort_engine_top failed");
    end
    $finish;
  end

  // Result side: random stalls, calm stretches and one long hold-off
  initial begin : result_sink
    int unsigned taken;
    int unsigned gap;
    int unsigned calm;
    taken        = 0;
    calm         = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      if (taken == HOLD_AT) begin
        gap = HOLD_CYCLES;
      end else if (calm > 0) begin
        calm--;
        gap = 0;
      end else begin
        gap = pick_gap();
        if ($urandom_range(0, 49) == 0) calm = $urandom_range(20, 80);
      end
      if (gap > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.sorted_value, out_ch.final_res);
  end

  initial begin : watchdog
    #2000000;
    $display("tb_merge_sort_engine_top failed");
    $finish;
  end

endmodule
